// File: sv/bdlp_pkg.sv
package bdlp_pkg;

    // Field and register widths
    localparam int unsigned TimeW     = 32;
    localparam int unsigned SettleW   = 10;
    localparam int unsigned LongW     = 16;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned EventW    = 3;

    // Register reset values
    localparam logic [SettleW-1:0] SettleReset = 10'd10;
    localparam logic [LongW-1:0]   LongReset   = 16'd1000;

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SETTLE_MS     = 2'd0,
        CFG_LONG_PRESS_MS = 2'd1
    } t_cfg_idx;

    // Debounced button state
    typedef enum logic [1:0] {
        PS_UP        = 2'd0,
        PS_UP_LONG   = 2'd1,
        PS_DOWN      = 2'd2,
        PS_DOWN_LONG = 2'd3
    } t_press;

    // Result codes
    typedef enum logic [EventW-1:0] {
        EV_NONE      = 3'd0,
        EV_UP        = 3'd1,
        EV_UP_LONG   = 3'd2,
        EV_DOWN      = 3'd3,
        EV_DOWN_LONG = 3'd4
    } t_event;

    // Everything the debouncer carries from one sample to the next
    typedef struct packed {
        logic             level_known;
        logic             last_level;
        logic [TimeW-1:0] settle_deadline;
        logic [TimeW-1:0] long_deadline;
        t_press           press;
    } t_state;

endpackage

// File: sv/bdlp_step.sv
// Next-state and result logic for one pin sample
module bdlp_step (
    input  bdlp_pkg::t_state                    i_state,
    input  logic [bdlp_pkg::SettleW-1:0]        i_settle_ms,
    input  logic [bdlp_pkg::LongW-1:0]          i_long_press_ms,
    input  logic                                i_pin_level,
    input  logic [bdlp_pkg::TimeW-1:0]          i_now_ms,
    output bdlp_pkg::t_state                    o_state,
    output bdlp_pkg::t_event                    o_event
);

    logic level_change;

    assign level_change = !i_state.level_known || (i_pin_level != i_state.last_level);

    // State update: level change restarts settling, else once settled run the press machine
    always_comb begin
        o_state = i_state;
        if (level_change) begin
            o_state.level_known     = 1'b1;
            o_state.last_level      = i_pin_level;
            o_state.settle_deadline = i_now_ms
                + {{(bdlp_pkg::TimeW-bdlp_pkg::SettleW){1'b0}}, i_settle_ms};
        end else if (i_now_ms >= i_state.settle_deadline) begin
            unique case (i_state.press)
                bdlp_pkg::PS_UP, bdlp_pkg::PS_UP_LONG: begin
                    if (!i_pin_level) begin
                        o_state.press         = bdlp_pkg::PS_DOWN;
                        o_state.long_deadline = i_now_ms
                            + {{(bdlp_pkg::TimeW-bdlp_pkg::LongW){1'b0}}, i_long_press_ms};
                    end
                end
                bdlp_pkg::PS_DOWN: begin
                    if (i_pin_level) begin
                        o_state.press = bdlp_pkg::PS_UP;
                    end else if (i_now_ms > i_state.long_deadline) begin
                        o_state.press = bdlp_pkg::PS_DOWN_LONG;
                    end
                end
                default: begin
                    if (i_pin_level) begin
                        o_state.press = bdlp_pkg::PS_UP_LONG;
                    end
                end
            endcase
        end
    end

    // Report the new state only on a change
    always_comb begin
        o_event = bdlp_pkg::EV_NONE;
        if (o_state.press != i_state.press) begin
            unique case (o_state.press)
                bdlp_pkg::PS_UP:        o_event = bdlp_pkg::EV_UP;
                bdlp_pkg::PS_UP_LONG:   o_event = bdlp_pkg::EV_UP_LONG;
                bdlp_pkg::PS_DOWN:      o_event = bdlp_pkg::EV_DOWN;
                default:                o_event = bdlp_pkg::EV_DOWN_LONG;
            endcase
        end
    end

endmodule

// File: sv/button_debounce_long_press_unit.sv
// Active-low push-button debouncer with long-press detection.
//
// Input channel (i_in_valid / o_in_ready): one request per pin sample,
// carrying the pin level (0 pressed) and the millisecond time of the sample.
// Output channel (o_out_valid / i_out_ready): exactly one result per request,
// in order: 0 no change, 1 up, 2 up after long, 3 down, 4 long down.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets the
// settle time, index 1 the long-press time; other indexes are ignored.
//
// A request waits in the sample register, then the state update (32-bit adds
// and compares) loads the result register, which drives the result port.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the sample register still takes one further
// request, so o_in_ready drops only when both stages hold data.
// Reset clears both stages, sets the registers to 10 ms and 1000 ms, puts the
// button in the up state and marks the level unknown, so the first sample
// always counts as a level change.
module button_debounce_long_press_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_pin_level,
    input  logic [bdlp_pkg::TimeW-1:0]         i_now_ms,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bdlp_pkg::EventW-1:0]        o_event_res,
    // config channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bdlp_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [bdlp_pkg::CfgDataW-1:0]      i_cfg_data
);

    logic [bdlp_pkg::SettleW-1:0] r_settle_ms;
    logic [bdlp_pkg::LongW-1:0]   r_long_press_ms;

    logic                         r_in_valid;
    logic                         r_pin_level;
    logic [bdlp_pkg::TimeW-1:0]   r_now_ms;

    logic                         r_out_valid;
    bdlp_pkg::t_event             r_event;

    bdlp_pkg::t_state             r_state;
    bdlp_pkg::t_state             n_state;
    bdlp_pkg::t_event             n_event;

    logic                         in_accept;
    logic                         advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ms     <= bdlp_pkg::SettleReset;
            r_long_press_ms <= bdlp_pkg::LongReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdlp_pkg::CFG_SETTLE_MS:     r_settle_ms     <= i_cfg_data[bdlp_pkg::SettleW-1:0];
                bdlp_pkg::CFG_LONG_PRESS_MS: r_long_press_ms <= i_cfg_data[bdlp_pkg::LongW-1:0];
                default: ;
            endcase
        end
    end

    // Sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pin_level <= i_pin_level;
            r_now_ms    <= i_now_ms;
        end
    end

    bdlp_step u_step (
        .i_state         (r_state),
        .i_settle_ms     (r_settle_ms),
        .i_long_press_ms (r_long_press_ms),
        .i_pin_level     (r_pin_level),
        .i_now_ms        (r_now_ms),
        .o_state         (n_state),
        .o_event         (n_event)
    );

    // Debounce state, advanced once per sample leaving the sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level_known     <= 1'b0;
            r_state.last_level      <= 1'b0;
            r_state.settle_deadline <= '0;
            r_state.long_deadline   <= '0;
            r_state.press           <= bdlp_pkg::PS_UP;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event <= n_event;
        end
    end

endmodule

// File: sv/bdlp_checker.sv
// Port-level checks on the debouncer
module bdlp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [bdlp_pkg::EventW-1:0]   o_event_res
);

    // Input only stalls while a result is waiting on the receiver
    a_stall_only_on_backpressure: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready)
    ) else $error("input stalled without output backpressure");

    // Every accepted request is followed by a valid result on the port
    a_result_follows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 o_out_valid
    ) else $error("no result after accepted request");

    // Only defined result codes
    a_code_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res <= bdlp_pkg::EventW'(bdlp_pkg::EV_DOWN_LONG))
    ) else $error("undefined result code");

    // A stalled result holds
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_event_res))
    ) else $error("result changed while stalled");

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_event_res (o_event_res)
);
